FILE: design/pfbs_pkg.sv
// ---------------------------------------------------------------------------
// pfbs_pkg
// Types and constants shared by the byte stuffing packet framer.
// ---------------------------------------------------------------------------
package pfbs_pkg;

   localparam logic [7:0] ESC_BYTE  = 8'hFE;
   localparam logic [7:0] ESC_NL    = 8'hFD;
   localparam logic [7:0] ESC_ESC   = 8'hFC;
   localparam logic [7:0] NL_BYTE   = 8'h0A;
   localparam logic [5:0] PREAMBLE  = 6'h3E;
   localparam logic [1:0] HLEN_BITS = 2'b10;  // bits 5..4 of header byte 1 (0x20)

   localparam int DESC_BYTES  = 6;
   localparam int DESC_IDX_W  = 3;
   localparam int Q_DEPTH     = 2;
   localparam int Q_PTR_W     = 1;
   localparam int Q_CNT_W     = 2;

   typedef enum logic [1:0] {
      OP_HEADER  = 2'd0,
      OP_PAYLOAD = 2'd1,
      OP_TRAILER = 2'd2,
      OP_UNUSED  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [1:0]  priority_req;
      logic [1:0]  flag_bits;
      logic [3:0]  hop_limit;
      logic [7:0]  source_address;
      logic [7:0]  dest_address;
      logic [7:0]  source_port;
      logic [7:0]  dest_port;
      logic [7:0]  payload_byte;
      logic [31:0] check_word;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_end;
   } rsp_type;

   // one classified item: raw bytes to stuff, their count, and the closing newline
   typedef struct packed {
      logic [DESC_BYTES-1:0][7:0] bytes;
      logic [DESC_IDX_W-1:0]      count;
      logic                       has_nl;
   } desc_type;

   typedef struct packed {
      logic     push;
      desc_type desc;
   } qwr_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } qrd_type;

endpackage

FILE: design/packet_frame_byte_stuffer_top.sv
// ---------------------------------------------------------------------------
// packet_frame_byte_stuffer_top
// Transmit framer: header, payload and crc trailer items to stuffed bytes.
// ---------------------------------------------------------------------------
// an item's first byte reaches rsp through the descriptor queue, then the output register
// throughput: one output byte per cycle while rsp is not stalled, set by the single output register;
//   an item makes 1 to 11 bytes
// a two-entry descriptor queue lets new items enter while bytes drain
// reset (synchronous, active high) empties the queue and the output register
// ---------------------------------------------------------------------------
module packet_frame_byte_stuffer_top
   import pfbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   qwr_type q_wr;     // front to queue: push and descriptor
   qrd_type q_rd;     // queue head seen by the back part
   logic    q_full;
   logic    q_pop;    // back part finished the head descriptor

   // front: classify each request transfer into raw bytes
   pfbs_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_wr      (q_wr)
   );

   // decoupling queue
   pfbs_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   // back: stuff and send one byte per response transfer
   pfbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_rd      (q_rd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/pfbs_front.sv
// ---------------------------------------------------------------------------
// pfbs_front
// Accepts request transfers and builds a raw byte descriptor for each, dropping unused codes.
// ---------------------------------------------------------------------------
module pfbs_front
   import pfbs_pkg::*;
(
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output qwr_type q_wr
);

   desc_type desc;

   always_comb begin
      desc       = '0;
      q_wr.push  = 1'b0;
      case (req_data.operation)
         OP_HEADER: begin
            desc.bytes[0] = {req_data.priority_req, PREAMBLE};
            desc.bytes[1] = {req_data.flag_bits, HLEN_BITS, req_data.hop_limit};
            desc.bytes[2] = req_data.source_address;
            desc.bytes[3] = req_data.dest_address;
            desc.bytes[4] = req_data.source_port;
            desc.bytes[5] = req_data.dest_port;
            desc.count    = DESC_IDX_W'(6);
            q_wr.push     = req_valid && !q_full;
         end
         OP_PAYLOAD: begin
            desc.bytes[0] = req_data.payload_byte;
            desc.count    = DESC_IDX_W'(1);
            q_wr.push     = req_valid && !q_full;
         end
         OP_TRAILER: begin
            // crc goes out low byte first
            desc.bytes[0] = req_data.check_word[7:0];
            desc.bytes[1] = req_data.check_word[15:8];
            desc.bytes[2] = req_data.check_word[23:16];
            desc.bytes[3] = req_data.check_word[31:24];
            desc.count    = DESC_IDX_W'(4);
            desc.has_nl   = 1'b1;
            q_wr.push     = req_valid && !q_full;
         end
         default: begin
            // unused code: accepted and dropped
            q_wr.push = 1'b0;
         end
      endcase
      q_wr.desc = desc;
   end

   assign req_stall = q_full;

endmodule

FILE: design/pfbs_queue.sv
// ---------------------------------------------------------------------------
// pfbs_queue
// Short descriptor queue between the front and back parts.
// ---------------------------------------------------------------------------
module pfbs_queue
   import pfbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  qwr_type q_wr,
   output logic    q_full,
   output qrd_type q_rd,
   input  logic    q_pop
);

   desc_type             mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                 do_pop;

   assign q_full     = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign q_rd.valid = (cnt_ff != '0);
   assign q_rd.desc  = mem_ff[rd_ptr_ff];
   assign do_pop     = q_pop && q_rd.valid;

   always_comb begin
      wr_ptr_in = q_wr.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (q_wr.push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!q_wr.push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) begin
         mem_ff[wr_ptr_ff] <= q_wr.desc;
      end
   end

endmodule

FILE: design/pfbs_back.sv
// ---------------------------------------------------------------------------
// pfbs_back
// Walks a descriptor byte by byte, stuffs it and drives the output register.
// ---------------------------------------------------------------------------
module pfbs_back
   import pfbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  qrd_type q_rd,
   output logic    q_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [DESC_IDX_W-1:0] idx_ff, idx_in;
   logic                  esc_ff, esc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  load;
   logic                  is_last_byte;
   logic [7:0]            cur;

   assign load         = !rsp_valid_ff || !rsp_stall;
   assign cur          = q_rd.desc.bytes[idx_ff];
   assign is_last_byte = (idx_ff == q_rd.desc.count - 1'b1) && !q_rd.desc.has_nl;

   always_comb begin
      idx_in       = idx_ff;
      esc_in       = esc_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load && q_rd.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (idx_ff == q_rd.desc.count) begin
            // closing newline, never stuffed
            rsp_data_in.out_byte    = NL_BYTE;
            rsp_data_in.last_of_run = 1'b1;
            rsp_data_in.frame_end   = 1'b1;
            idx_in                  = '0;
            q_pop                   = 1'b1;
         end else if (esc_ff) begin
            rsp_data_in.out_byte    = (cur == NL_BYTE) ? ESC_NL : ESC_ESC;
            rsp_data_in.last_of_run = is_last_byte;
            esc_in                  = 1'b0;
            idx_in                  = is_last_byte ? '0 : idx_ff + 1'b1;
            q_pop                   = is_last_byte;
         end else if (cur == NL_BYTE || cur == ESC_BYTE) begin
            rsp_data_in.out_byte = ESC_BYTE;
            esc_in               = 1'b1;
         end else begin
            rsp_data_in.out_byte    = cur;
            rsp_data_in.last_of_run = is_last_byte;
            idx_in                  = is_last_byte ? '0 : idx_ff + 1'b1;
            q_pop                   = is_last_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/tb_packet_frame_byte_stuffer_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_packet_frame_byte_stuffer_top
// Self-checking bench for the byte stuffing transmit framer: a short table of
// hand-picked items, then random frames with noise, random gaps on the request
// side and random stall on the response side, each byte checked in order.
// ---------------------------------------------------------------------------
module tb_packet_frame_byte_stuffer_top;
   import pfbs_pkg::*;

   // directed row: item plus hand-typed bytes, or n_typed < 0 for the predictor
   typedef struct {
      req_type     item;
      int          n_typed;
      logic [95:0] typed_bytes;   // first byte in the most significant used slot
   } vector_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type        expected_bytes[$];   // framed bytes still owed by the block
   vector_row_type vec_rows[$];
   bit             quiet;               // no gaps and no stall while set
   int unsigned    rx_hold;             // stall cycles left before the next transfer
   int unsigned    err_count;
   int unsigned    items_sent;
   int unsigned    bytes_seen;
   int unsigned    frames_closed;
   int unsigned    escapes_seen;

   packet_frame_byte_stuffer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("packet_frame_byte_stuffer_top verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      err_count++;
   endtask

   // one byte after stuffing: newline and escape become two-byte pairs
   function automatic void stuff_byte(input logic [7:0] b);
      rsp_type e;
      e.last_of_run = 1'b0;
      e.frame_end   = 1'b0;
      if (b == NL_BYTE || b == ESC_BYTE) begin
         e.out_byte = ESC_BYTE;
         expected_bytes.push_back(e);
         e.out_byte = (b == NL_BYTE) ? ESC_NL : ESC_ESC;
      end else begin
         e.out_byte = b;
      end
      expected_bytes.push_back(e);
   endfunction

   // bytes that one accepted item must produce
   function automatic void predict_frame_bytes(input req_type it);
      int unsigned start;
      rsp_type     nl;
      start = expected_bytes.size();
      case (it.operation)
         OP_HEADER: begin
            stuff_byte({it.priority_req, PREAMBLE});
            stuff_byte({it.flag_bits, HLEN_BITS, it.hop_limit});
            stuff_byte(it.source_address);
            stuff_byte(it.dest_address);
            stuff_byte(it.source_port);
            stuff_byte(it.dest_port);
         end
         OP_PAYLOAD: begin
            stuff_byte(it.payload_byte);
         end
         OP_TRAILER: begin
            // crc goes out low byte first, closing newline is never stuffed
            for (int i = 0; i < 4; i++) stuff_byte(it.check_word[8*i +: 8]);
            nl.out_byte    = NL_BYTE;
            nl.last_of_run = 1'b0;
            nl.frame_end   = 1'b1;
            expected_bytes.push_back(nl);
         end
         default: ;   // unused code makes nothing
      endcase
      if (expected_bytes.size() > start)
         expected_bytes[expected_bytes.size()-1].last_of_run = 1'b1;
   endfunction

   // hand-typed bytes from a directed row
   function automatic void queue_typed(input op_type op, input int n, input logic [95:0] b);
      rsp_type e;
      for (int i = 0; i < n; i++) begin
         e.out_byte    = b[8*(n-1-i) +: 8];
         e.last_of_run = (i == n - 1);
         e.frame_end   = (i == n - 1) && (op == OP_TRAILER);
         expected_bytes.push_back(e);
      end
   endfunction

   // byte values leaning on the two that need stuffing
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return NL_BYTE;
         1: return ESC_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // all fields random; fields outside the item's kind must be ignored
   function automatic req_type rand_req(input op_type op);
      req_type r;
      r.operation      = op;
      r.priority_req   = 2'($urandom_range(0, 3));
      r.flag_bits      = 2'($urandom_range(0, 3));
      r.hop_limit      = 4'($urandom_range(0, 15));
      r.source_address = pick_byte();
      r.dest_address   = pick_byte();
      r.source_port    = pick_byte();
      r.dest_port      = pick_byte();
      r.payload_byte   = pick_byte();
      r.check_word     = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
      return r;
   endfunction

   function automatic req_type hdr(input logic [1:0] pri, input logic [1:0] flg,
                                   input logic [3:0] ttl, input logic [7:0] sa,
                                   input logic [7:0] da, input logic [7:0] sp,
                                   input logic [7:0] dp);
      req_type r;
      r = rand_req(OP_HEADER);
      r.priority_req   = pri;
      r.flag_bits      = flg;
      r.hop_limit      = ttl;
      r.source_address = sa;
      r.dest_address   = da;
      r.source_port    = sp;
      r.dest_port      = dp;
      return r;
   endfunction

   function automatic req_type pay(input logic [7:0] b);
      req_type r;
      r = rand_req(OP_PAYLOAD);
      r.payload_byte = b;
      return r;
   endfunction

   function automatic req_type trl(input logic [31:0] w);
      req_type r;
      r = rand_req(OP_TRAILER);
      r.check_word = w;
      return r;
   endfunction

   function automatic void add_row(input req_type it, input int n, input logic [95:0] b);
      vector_row_type v;
      v.item        = it;
      v.n_typed     = n;
      v.typed_bytes = b;
      vec_rows.push_back(v);
   endfunction

   // drive one item at the falling edge after a random gap, wait for its transfer
   task automatic send_item(input req_type it, input int typed_n, input logic [95:0] typed_b);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer taken at this edge
      if (typed_n < 0) predict_frame_bytes(it);
      else queue_typed(it.operation, typed_n, typed_b);
      if (it.operation != OP_UNUSED) items_sent++;
   endtask

   // hold off the sender until every owed byte has come out
   task automatic drain_pause();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // response side: stall drawn per transfer, released at the falling edge
   always @(negedge clock) begin
      if (rx_hold != 0) begin
         rsp_stall <= 1'b1;
         rx_hold = rx_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_seen++;
         if (rsp_data.out_byte == ESC_BYTE) escapes_seen++;
         if (rsp_data.frame_end) frames_closed++;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_data.out_byte));
         end else begin
            e = expected_bytes.pop_front();
            if (rsp_data.out_byte !== e.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_data.out_byte, e.out_byte));
            if (rsp_data.last_of_run !== e.last_of_run)
               report_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                         rsp_data.last_of_run, e.last_of_run, e.out_byte));
            if (rsp_data.frame_end !== e.frame_end)
               report_mismatch($sformatf("frame_end %b, want %b on byte %02h",
                                         rsp_data.frame_end, e.frame_end, e.out_byte));
         end
         rx_hold = quiet ? 0 : $urandom_range(0, 11);
      end
   end

   initial begin
      int unsigned   rand_items;
      int unsigned   n_pay;
      bit            paused;
      req_type       it;
      logic [95:0]   none;

      none       = '0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      rx_hold    = 0;
      quiet      = 1'b0;
      err_count  = 0;
      items_sent = 0;
      paused     = 1'b0;

      // hold synchronous reset, then release it at a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows: byte extremes and both escapes
      add_row(pay(8'h00), 1, 96'({8'h00}));
      add_row(pay(8'hFF), 1, 96'({8'hFF}));
      add_row(pay(8'h0A), 2, 96'({8'hFE, 8'hFD}));
      add_row(pay(8'hFE), 2, 96'({8'hFE, 8'hFC}));
      add_row(pay(8'hFD), 1, 96'({8'hFD}));
      add_row(pay(8'hFC), 1, 96'({8'hFC}));
      // header with all fields low, all high, and every address and port byte escaped
      add_row(hdr(2'd0, 2'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00), 6,
              96'({8'h3E, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00}));
      add_row(hdr(2'd3, 2'd3, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 7,
              96'({8'hFE, 8'hFC, 8'hEF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
      add_row(hdr(2'd3, 2'd0, 4'd0, 8'h0A, 8'hFE, 8'h0A, 8'hFE), 11,
              96'({8'hFE, 8'hFC, 8'h20, 8'hFE, 8'hFD, 8'hFE, 8'hFC,
                   8'hFE, 8'hFD, 8'hFE, 8'hFC}));
      add_row(hdr(2'd1, 2'd2, 4'd5, 8'h5A, 8'hA5, 8'h01, 8'h80), -1, none);
      add_row(hdr(2'd2, 2'd1, 4'd10, 8'h3C, 8'hC3, 8'h0A, 8'h7F), -1, none);
      // trailers: zero, all ones, every byte escaped, byte order
      add_row(trl(32'h0000_0000), 5, 96'({8'h00, 8'h00, 8'h00, 8'h00, 8'h0A}));
      add_row(trl(32'hFFFF_FFFF), 5, 96'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0A}));
      add_row(trl(32'hFE0A_0AFE), 9,
              96'({8'hFE, 8'hFC, 8'hFE, 8'hFD, 8'hFE, 8'hFD, 8'hFE, 8'hFC, 8'h0A}));
      add_row(trl(32'h1234_5678), 5, 96'({8'h78, 8'h56, 8'h34, 8'h12, 8'h0A}));
      // unused code is dropped, with other fields low and high
      it = '0;
      it.operation = OP_UNUSED;
      add_row(it, 0, none);
      it = '1;
      add_row(it, 0, none);
      add_row(pay(8'h0A), 2, 96'({8'hFE, 8'hFD}));
      // payload and trailer out of frame order, random content
      add_row(rand_req(OP_PAYLOAD), -1, none);
      add_row(rand_req(OP_TRAILER), -1, none);
      add_row(rand_req(OP_HEADER), -1, none);

      foreach (vec_rows[i])
         send_item(vec_rows[i].item, vec_rows[i].n_typed, vec_rows[i].typed_bytes);

      // let the directed bytes drain before the random part
      drain_pause();

      // random part: mostly whole frames, some noise and broken frames
      rand_items = 0;
      while (rand_items < 250) begin
         quiet = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            8: begin
               // noise: one item of any code, unused one included
               it = rand_req(op_type'($urandom_range(0, 3)));
               send_item(it, -1, none);
               if (it.operation != OP_UNUSED) rand_items++;
            end
            9: begin
               // broken frame: payload run without header, or a double header
               if ($urandom_range(0, 1) == 1) send_item(rand_req(OP_HEADER), -1, none);
               else send_item(rand_req(OP_PAYLOAD), -1, none);
               send_item(rand_req(OP_HEADER), -1, none);
               send_item(rand_req(OP_PAYLOAD), -1, none);
               rand_items += 3;
            end
            default: begin
               // well-formed frame: header, a few payload bytes, crc trailer
               n_pay = $urandom_range(0, 6);
               send_item(rand_req(OP_HEADER), -1, none);
               repeat (n_pay) send_item(rand_req(OP_PAYLOAD), -1, none);
               send_item(rand_req(OP_TRAILER), -1, none);
               rand_items += n_pay + 2;
            end
         endcase
         // one more full pause midway through
         if (!paused && rand_items >= 120) begin
            drain_pause();
            paused = 1'b1;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      quiet = 1'b0;

      // wait out the owed bytes, then keep idling to catch any stray output
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("covered %0d framed items, %0d bytes out, %0d frames closed",
               items_sent, bytes_seen, frames_closed);
      $display("escape bytes seen %0d, mismatches %0d", escapes_seen, err_count);
      if (err_count == 0) begin
         $display("packet_frame_byte_stuffer_top verification clean");
      end else begin
         $display("packet_frame_byte_stuffer_top verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/pfbs_pkg.sv
design/pfbs_front.sv
design/pfbs_queue.sv
design/pfbs_back.sv
design/packet_frame_byte_stuffer_top.sv
test/tb_packet_frame_byte_stuffer_top.sv
